/* hdl/kls_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the k-th largest sorted multiset block.
// No dependencies; every other file refers to it by scoped names.
package kls_pkg;

	localparam int CAPACITY = 64;
	localparam int KEY_W    = 32;
	localparam int CNT_W    = 7;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int GRP_SIZE = 8;
	localparam int GRP_N    = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [CNT_W-1:0]        cnt_t;
	typedef logic [IDX_W-1:0]        idx_t;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;

	localparam cnt_t CAP_CNT = CNT_W'(CAPACITY);

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_SHIFT
	} cell_op_t;

	// command broadcast to every cell
	typedef struct packed {
		cell_op_t code;
		key_t     key;
	} cell_cmd_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_RESP
	} state_t;

endpackage

/* hdl/kls_cell.sv */
`timescale 1ns / 1ps
// One cell of the sorted row: holds one key and its valid flag.
// Depends on kls_pkg for key and command types.
module kls_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  kls_pkg::cell_cmd_t  cmd,
	input  kls_pkg::key_t       left_key,
	input  logic                left_valid,
	input  logic                left_le,
	input  kls_pkg::key_t       right_key,
	input  logic                right_valid,
	output kls_pkg::key_t       cell_key,
	output logic                cell_valid,
	output logic                le,
	output logic                eq
);

	kls_pkg::key_t key_q;
	kls_pkg::key_t key_d;
	logic          valid_q;
	logic          valid_d;
	logic          ge;

	assign le = valid_q && (key_q <= cmd.key);
	assign ge = valid_q && (key_q >= cmd.key);
	assign eq = valid_q && (key_q == cmd.key);

	// insert: cells at or after the slot shift right; delete: cells at or after
	// the first match shift left, dropping one copy per cycle
	always_comb begin
		key_d   = key_q;
		valid_d = valid_q;
		case (cmd.code)
			kls_pkg::CELL_INSERT: begin
				if (!le) begin
					if (left_le) begin
						key_d   = cmd.key;
						valid_d = 1'b1;
					end else begin
						key_d   = left_key;
						valid_d = left_valid;
					end
				end
			end
			kls_pkg::CELL_SHIFT: begin
				if (ge) begin
					key_d   = right_key;
					valid_d = right_valid;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		key_q <= key_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	assign cell_key   = key_q;
	assign cell_valid = valid_q;

endmodule

/* hdl/kls_rank_sel.sv */
`timescale 1ns / 1ps
// Picks one cell's key by position: registered group OR, then a final OR.
// Depends on kls_pkg for sizes and types.
module kls_rank_sel (
	input  logic                                   clk,
	input  logic [kls_pkg::CAPACITY-1:0][kls_pkg::KEY_W-1:0] keys,
	input  kls_pkg::idx_t                          sel,
	output kls_pkg::key_t                          found
);

	localparam int PAD_N = kls_pkg::GRP_N * kls_pkg::GRP_SIZE;

	logic [PAD_N-1:0][kls_pkg::KEY_W-1:0]         keys_pad;
	logic [kls_pkg::GRP_N-1:0][kls_pkg::KEY_W-1:0] grp_d;
	logic [kls_pkg::GRP_N-1:0][kls_pkg::KEY_W-1:0] grp_s1;
	logic [kls_pkg::KEY_W-1:0]                     acc;

	always_comb begin
		keys_pad = '0;
		for (int i = 0; i < kls_pkg::CAPACITY; i++) begin
			keys_pad[i] = keys[i];
		end
	end

	always_comb begin
		for (int g = 0; g < kls_pkg::GRP_N; g++) begin
			grp_d[g] = '0;
			for (int j = 0; j < kls_pkg::GRP_SIZE; j++) begin
				if ((g * kls_pkg::GRP_SIZE + j < kls_pkg::CAPACITY) &&
				    (sel == kls_pkg::IDX_W'(g * kls_pkg::GRP_SIZE + j))) begin
					grp_d[g] = grp_d[g] | keys_pad[g * kls_pkg::GRP_SIZE + j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		grp_s1 <= grp_d;
	end

	always_comb begin
		acc = '0;
		for (int g = 0; g < kls_pkg::GRP_N; g++) begin
			acc = acc | grp_s1[g];
		end
	end

	assign found = kls_pkg::key_t'(acc);

endmodule

/* hdl/kth_largest_sorted_multiset_top.sv */
`timescale 1ns / 1ps
// Top level of the k-th largest sorted multiset: control, cell row, rank select.
// Depends on kls_pkg, kls_cell and kls_rank_sel.
//
//  channel | signals                          | direction | transaction
//  --------+----------------------------------+-----------+-----------------------------
//  input   | in_valid, in_ready, op/key/rank  | in        | one insert, delete or query
//  output  | out_valid, out_ready,            | out       | one result per input
//          | found_key/status/stored_count    |           |
//
// Steps: insert and op code three run the execute, then the response state; a query
// with a legal rank runs the read state between them for the registered group select.
// A delete repeats the execute state while a copy matches, dropping one copy per cycle.
// One transaction is in flight at a time; the next input is taken once the
// result sits in the output register, even while that result is stalled.
// Reset clears the valid flag of every cell, the count and the output valid.
// Output stalls hold the result register; the engine waits in its response state.
module kth_largest_sorted_multiset_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          op,
	input  logic signed [31:0]  key,
	input  logic [6:0]          rank,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  found_key,
	output logic [1:0]          status,
	output logic [6:0]          stored_count
);

	localparam int N = kls_pkg::CAPACITY;

	kls_pkg::state_t    state_q;
	kls_pkg::state_t    state_d;

	// latched transaction
	logic [1:0]         op_q;
	kls_pkg::key_t      key_q;
	kls_pkg::cnt_t      rank_q;

	kls_pkg::cnt_t      count_q;
	kls_pkg::cnt_t      count_d;
	logic [1:0]         stat_q;
	logic [1:0]         stat_d;
	kls_pkg::key_t      found_q;

	logic               out_valid_q;
	kls_pkg::key_t      out_key_q;
	logic [1:0]         out_stat_q;
	kls_pkg::cnt_t      out_cnt_q;

	logic               accept;
	logic               resp_load;
	logic               read_go;
	kls_pkg::cell_cmd_t cmd;
	kls_pkg::idx_t      idx_full;
	logic               rank_bad;
	logic               any_eq;
	kls_pkg::key_t      sel_key;

	// cell row wiring
	logic [N-1:0][kls_pkg::KEY_W-1:0] cell_key;
	logic [N-1:0]                     cell_valid;
	logic [N-1:0]                     cell_le;
	logic [N-1:0]                     cell_eq;

	assign in_ready  = (state_q == kls_pkg::S_IDLE);
	assign accept    = in_valid && in_ready;
	assign resp_load = (state_q == kls_pkg::S_RESP) && (!out_valid_q || out_ready);
	assign any_eq    = |cell_eq;

	// rank counted from the top: position count - rank, valid for 1..count
	assign idx_full = kls_pkg::idx_t'(count_q - rank_q);
	assign rank_bad = (rank_q == '0) || (rank_q > count_q);

	// ---------------- cell row ----------------
	for (genvar i = 0; i < N; i++) begin : g_cell
		kls_pkg::key_t lk;
		logic          lv;
		logic          ll;
		kls_pkg::key_t rk;
		logic          rv;

		if (i == 0) begin : g_first
			assign lk = '0;
			assign lv = 1'b1;
			assign ll = 1'b1;   // left edge counts as "all smaller"
		end else begin : g_mid
			assign lk = kls_pkg::key_t'(cell_key[i-1]);
			assign lv = cell_valid[i-1];
			assign ll = cell_le[i-1];
		end

		if (i == N - 1) begin : g_last
			assign rk = '0;
			assign rv = 1'b0;
		end else begin : g_inner
			assign rk = kls_pkg::key_t'(cell_key[i+1]);
			assign rv = cell_valid[i+1];
		end

		kls_pkg::key_t ck;

		kls_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.left_key   (lk),
			.left_valid (lv),
			.left_le    (ll),
			.right_key  (rk),
			.right_valid(rv),
			.cell_key   (ck),
			.cell_valid (cell_valid[i]),
			.le         (cell_le[i]),
			.eq         (cell_eq[i])
		);

		assign cell_key[i] = ck;
	end

	kls_rank_sel u_sel (
		.clk   (clk),
		.keys  (cell_key),
		.sel   (idx_full),
		.found (sel_key)
	);

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kls_pkg::S_IDLE: begin
				if (accept) begin
					state_d = kls_pkg::S_EXEC;
				end
			end
			kls_pkg::S_EXEC: begin
				if (op_q == kls_pkg::OP_DELETE && any_eq) begin
					state_d = kls_pkg::S_EXEC;
				end else if (read_go) begin
					state_d = kls_pkg::S_READ;
				end else begin
					state_d = kls_pkg::S_RESP;
				end
			end
			kls_pkg::S_READ: begin
				state_d = kls_pkg::S_RESP;
			end
			kls_pkg::S_RESP: begin
				if (resp_load) begin
					state_d = kls_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = kls_pkg::S_IDLE;
			end
		endcase
	end

	// ---------------- outputs of the state machine ----------------
	always_comb begin
		cmd.code = kls_pkg::CELL_HOLD;
		cmd.key  = key_q;
		count_d  = count_q;
		stat_d   = stat_q;
		read_go  = 1'b0;
		unique case (state_q)
			kls_pkg::S_EXEC: begin
				case (op_q)
					kls_pkg::OP_INSERT: begin
						if (count_q >= kls_pkg::CAP_CNT) begin
							stat_d = kls_pkg::STAT_FULL;
						end else begin
							cmd.code = kls_pkg::CELL_INSERT;
							count_d  = count_q + kls_pkg::cnt_t'(1);
						end
					end
					kls_pkg::OP_DELETE: begin
						if (any_eq) begin
							cmd.code = kls_pkg::CELL_SHIFT;
							count_d  = count_q - kls_pkg::cnt_t'(1);
						end
					end
					kls_pkg::OP_QUERY: begin
						if (rank_bad) begin
							stat_d = kls_pkg::STAT_RANGE;
						end else begin
							read_go = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kls_pkg::S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (resp_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op;
			key_q   <= kls_pkg::key_t'(key);
			rank_q  <= kls_pkg::cnt_t'(rank);
			stat_q  <= kls_pkg::STAT_OK;
			found_q <= '0;
		end else begin
			stat_q <= stat_d;
			if (state_q == kls_pkg::S_READ) begin
				found_q <= sel_key;
			end
		end
		if (resp_load) begin
			out_key_q  <= found_q;
			out_stat_q <= stat_q;
			out_cnt_q  <= count_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign found_key    = out_key_q;
	assign status       = out_stat_q;
	assign stored_count = out_cnt_q;

endmodule

/* tb/kls_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the k-th largest sorted multiset: predicts each result, compares on output.
// Depends on kls_pkg for key, count, op and status definitions.
module kls_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_ready,
	input  logic [1:0]     op,
	input  kls_pkg::key_t  key,
	input  logic [6:0]     rank,
	input  logic           out_valid,
	input  logic           out_ready,
	input  kls_pkg::key_t  found_key,
	input  logic [1:0]     status,
	input  kls_pkg::cnt_t  stored_count,
	output int             fail_count,
	output int             pending,
	output int             held,
	output int             checked,
	output int             full_drops,
	output int             range_misses
);

	typedef struct packed {
		kls_pkg::key_t found;
		logic [1:0]    stat;
		kls_pkg::cnt_t count;
	} answer_t;

	kls_pkg::key_t multiset[kls_pkg::CAPACITY];   // ascending, entries below n_keys are valid
	int            n_keys;
	answer_t       answers_q[$];
	answer_t       want;
	int            fails;
	int            n_checked;
	int            n_full;
	int            n_range;

	// apply one transaction to the shadow multiset and return its answer
	function automatic answer_t apply_op(input logic [1:0] code, input kls_pkg::key_t k,
			input logic [6:0] r);
		answer_t a;
		int      i;
		int      j;
		a = '{found: '0, stat: kls_pkg::STAT_OK, count: '0};
		case (code)
			kls_pkg::OP_INSERT: begin
				if (n_keys >= kls_pkg::CAPACITY) begin
					a.stat = kls_pkg::STAT_FULL;
				end else begin
					// equal keys stay ahead of the new one
					i = 0;
					while (i < n_keys && multiset[i] <= k)
						i++;
					for (j = n_keys; j > i; j--)
						multiset[j] = multiset[j-1];
					multiset[i] = k;
					n_keys++;
				end
			end
			kls_pkg::OP_DELETE: begin
				j = 0;
				for (i = 0; i < n_keys; i++) begin
					if (multiset[i] != k) begin
						multiset[j] = multiset[i];
						j++;
					end
				end
				n_keys = j;
			end
			kls_pkg::OP_QUERY: begin
				if (r == 0 || int'(r) > n_keys)
					a.stat = kls_pkg::STAT_RANGE;
				else
					a.found = multiset[n_keys - int'(r)];
			end
			default: ;   // spare code: no effect
		endcase
		a.count = kls_pkg::cnt_t'(n_keys);
		return a;
	endfunction

	task automatic check_result();
		if (answers_q.size() == 0) begin
			fails++;
			$display("%0t: result with no transaction pending: found_key %0d status %0d count %0d",
				$time, found_key, status, stored_count);
		end else begin
			want = answers_q.pop_front();
			n_checked++;
			if (want.stat == kls_pkg::STAT_FULL)
				n_full++;
			if (want.stat == kls_pkg::STAT_RANGE)
				n_range++;
			if (found_key !== want.found) begin
				fails++;
				$display("%0t: found_key mismatch: expected %0d, got %0d",
					$time, want.found, found_key);
			end
			if (status !== want.stat) begin
				fails++;
				$display("%0t: status mismatch: expected %0d, got %0d",
					$time, want.stat, status);
			end
			if (stored_count !== want.count) begin
				fails++;
				$display("%0t: stored_count mismatch: expected %0d, got %0d",
					$time, want.count, stored_count);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_keys = 0;
			answers_q.delete();
			fails = 0;
			n_checked = 0;
			n_full = 0;
			n_range = 0;
			fail_count <= 0;
			pending <= 0;
			held <= 0;
			checked <= 0;
			full_drops <= 0;
			range_misses <= 0;
		end else begin
			if (in_valid && in_ready)
				answers_q.push_back(apply_op(op, key, rank));
			if (out_valid && out_ready)
				check_result();
			fail_count <= fails;
			pending <= answers_q.size();
			held <= n_keys;
			checked <= n_checked;
			full_drops <= n_full;
			range_misses <= n_range;
		end
	end

endmodule

/* tb/kth_largest_sorted_multiset_top_tb.sv */
`timescale 1ns / 1ps
// Testbench top for kth_largest_sorted_multiset_top: clock, reset, stimulus and verdict.
// Depends on kls_pkg, kls_checker and the block itself.
module kth_largest_sorted_multiset_top_tb;

	localparam logic [1:0]    OP_SPARE = 2'd3;        // unused op code, must be a no-op
	localparam kls_pkg::key_t KEY_MAX  = 32'sh7fff_ffff;
	localparam kls_pkg::key_t KEY_MIN  = 32'sh8000_0000;
	localparam int            MAX_GAP  = 12;
	localparam int            LONG_HOLD = 200;        // cycles the receiver sits on one result
	localparam int            DRAIN_CYCLES = 100;     // longer than the worst delete, which empties a full store

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_ready;
	logic [1:0]    op;
	kls_pkg::key_t key;
	logic [6:0]    rank;
	logic          out_valid;
	logic          out_ready;
	kls_pkg::key_t found_key;
	logic [1:0]    status;
	kls_pkg::cnt_t stored_count;

	int fail_count;
	int pending;
	int held;
	int checked;
	int full_drops;
	int range_misses;

	// stimulus bookkeeping
	int n_sent;
	int n_ins;
	int n_del;
	int n_qry;
	int n_spare;
	bit tx_calm;                // sender runs back to back while set
	int hold_req;               // bumped by the stimulus to ask for a long output stall

	kth_largest_sorted_multiset_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.key          (key),
		.rank         (rank),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found_key    (found_key),
		.status       (status),
		.stored_count (stored_count)
	);

	kls_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.key          (key),
		.rank         (rank),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found_key    (found_key),
		.status       (status),
		.stored_count (stored_count),
		.fail_count   (fail_count),
		.pending      (pending),
		.held         (held),
		.checked      (checked),
		.full_drops   (full_drops),
		.range_misses (range_misses)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit: the slowest legal run is roughly 850 transactions, each with a sender
	// gap, a full-store delete and a receiver stall, about 0.9 ms. Allow 5 ms.
	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	// Keys: mostly a small pool so duplicates pile up and deletes hit several
	// copies; the rest are the extremes or fully random words.
	function automatic kls_pkg::key_t draw_key();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return kls_pkg::key_t'($urandom_range(0, 39)) - 20;
		else if (roll < 72)
			return KEY_MAX;
		else if (roll < 79)
			return KEY_MIN;
		else
			return kls_pkg::key_t'($urandom);
	endfunction

	// Ranks: mostly a legal rank for the current fill level, some drawn from
	// 0..64 so zero and above-count cases keep showing up.
	function automatic logic [6:0] draw_rank();
		if ($urandom_range(0, 99) < 20 || held == 0)
			return 7'($urandom_range(0, 64));
		else
			return 7'($urandom_range(1, held));
	endfunction

	// One input transaction: optional idle gap, then hold valid until taken.
	// Valid stays up across back-to-back transactions (single NBA per step).
	task automatic send(input logic [1:0] code, input kls_pkg::key_t k, input logic [6:0] r);
		int gap;
		if (n_sent % 40 == 0)
			tx_calm = ($urandom_range(0, 3) == 0);
		gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= code;
		key      <= k;
		rank     <= r;
		do @(posedge clk); while (!in_ready);
		n_sent++;
		case (code)
			kls_pkg::OP_INSERT: n_ins++;
			kls_pkg::OP_DELETE: n_del++;
			kls_pkg::OP_QUERY:  n_qry++;
			default:            n_spare++;
		endcase
	endtask

	// Stop offering and wait until the scoreboard holds no open transaction.
	// The first edge lets the checker's registered count catch the last accept.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Random traffic with a given mix (percent); about 2% spare codes, rest queries.
	task automatic run_mix(input int n, input int ins_pct, input int del_pct);
		int unsigned roll;
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 2)
				send(OP_SPARE, kls_pkg::key_t'($urandom), 7'($urandom));
			else if (roll < 2 + ins_pct)
				send(kls_pkg::OP_INSERT, draw_key(), 7'($urandom));
			else if (roll < 2 + ins_pct + del_pct)
				send(kls_pkg::OP_DELETE, ($urandom_range(0, 99) < 85) ?
					kls_pkg::key_t'($urandom_range(0, 39)) - 20 : draw_key(), 7'($urandom));
			else
				send(kls_pkg::OP_QUERY, kls_pkg::key_t'($urandom), draw_rank());
		end
	endtask

	// Output side: a random stall before every result, calm stretches with
	// ready held high, and a long hold-off on request so the block backs up.
	initial begin
		int hold_done;
		int n_rx;
		int stall;
		bit rx_calm;
		hold_done = 0;
		n_rx = 0;
		rx_calm = 1'b0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req != hold_done) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_done++;
			end else begin
				if (n_rx % 32 == 0)
					rx_calm = ($urandom_range(0, 3) == 0);
				stall = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				out_ready <= 1'b1;
				do @(posedge clk); while (!out_valid);
				n_rx++;
			end
		end
	end

	// Main sequence: reset, directed corner cases, then random phases.
	initial begin
		n_sent = 0;
		n_ins = 0;
		n_del = 0;
		n_qry = 0;
		n_spare = 0;
		tx_calm = 1'b0;
		hold_req <= 0;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		op       <= kls_pkg::OP_INSERT;
		key      <= '0;
		rank     <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store: queries out of range, delete of an absent key
		send(kls_pkg::OP_QUERY,  '0, 7'd1);
		send(kls_pkg::OP_QUERY,  '0, 7'd0);
		send(kls_pkg::OP_DELETE, kls_pkg::key_t'(5), 7'd0);
		// extremes and duplicates
		send(kls_pkg::OP_INSERT, KEY_MAX, 7'd0);
		send(kls_pkg::OP_INSERT, KEY_MIN, 7'd127);
		send(kls_pkg::OP_INSERT, '0, 7'd0);
		send(kls_pkg::OP_INSERT, kls_pkg::key_t'(-1), 7'd0);
		send(kls_pkg::OP_INSERT, KEY_MAX, 7'd0);
		send(kls_pkg::OP_INSERT, '0, 7'd0);
		// largest, smallest, one past the count, zero, all-ones and 64
		send(kls_pkg::OP_QUERY,  '0, 7'd1);
		send(kls_pkg::OP_QUERY,  '0, 7'd6);
		send(kls_pkg::OP_QUERY,  '0, 7'd7);
		send(kls_pkg::OP_QUERY,  '0, 7'd0);
		send(kls_pkg::OP_QUERY,  KEY_MAX, 7'd127);
		send(kls_pkg::OP_QUERY,  '0, 7'd64);
		// spare op code must leave the store alone
		send(OP_SPARE,  kls_pkg::key_t'(-1), 7'd127);
		// delete of the largest key drops both copies, no wrap to the smallest
		send(kls_pkg::OP_DELETE, KEY_MAX, 7'd0);
		send(kls_pkg::OP_QUERY,  '0, 7'd1);
		send(kls_pkg::OP_DELETE, kls_pkg::key_t'(12345), 7'd0);
		send(kls_pkg::OP_DELETE, KEY_MIN, 7'd0);
		send(kls_pkg::OP_DELETE, '0, 7'd0);
		// alternating bit patterns
		send(kls_pkg::OP_INSERT, kls_pkg::key_t'(32'h5555_5555), 7'd0);
		send(kls_pkg::OP_INSERT, kls_pkg::key_t'(32'haaaa_aaaa), 7'd0);
		send(kls_pkg::OP_QUERY,  '0, 7'd2);
		send(kls_pkg::OP_DELETE, kls_pkg::key_t'(-1), 7'd0);

		// insert-heavy: fills the store and keeps hitting the full case
		run_mix(250, 78, 5);

		// receiver goes quiet while the sender keeps pushing
		hold_req <= hold_req + 1;
		run_mix(250, 40, 25);

		// let everything drain before the delete-heavy phase
		wait_idle();
		run_mix(150, 15, 50);
		run_mix(200, 45, 20);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d transactions: %0d insert, %0d delete, %0d query, %0d spare op.",
			n_sent, n_ins, n_del, n_qry, n_spare);
		$display("Checked %0d results: %0d dropped on a full store, %0d rank out of range.",
			checked, full_drops, range_misses);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* filelist.f */
hdl/kls_pkg.sv
hdl/kls_cell.sv
hdl/kls_rank_sel.sv
hdl/kth_largest_sorted_multiset_top.sv
tb/kls_checker.sv
tb/kth_largest_sorted_multiset_top_tb.sv
